// File: rtl/bbpu_pkg.sv
// Shared types and constants for the box border policy unit.
package bbpu_pkg;

	localparam int CW = 32;
	localparam int RND_W = 32;
	localparam int DVW = CW + 1;

	localparam int CFG_DW = (CW > 32) ? 64 : 32;
	localparam int REG_STRIDE = CFG_DW / 8;
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int ADDR_W = REG_IDX_W + $clog2(REG_STRIDE);

	localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_Z = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SEED = 3'd7;

	localparam logic [1:0] MODE_REFLECT = 2'd0;
	localparam logic [1:0] MODE_WRAP = 2'd1;
	localparam logic [1:0] MODE_RANDOM = 2'd2;
	localparam logic [1:0] MODE_ERROR = 2'd3;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t goal_x;
		coord_t goal_y;
		coord_t goal_z;
		coord_t vel_x;
		coord_t vel_y;
		coord_t vel_z;
		coord_t heading;
	} in_item_t;

	typedef struct packed {
		coord_t new_pos_x;
		coord_t new_pos_y;
		coord_t new_pos_z;
		coord_t new_goal_x;
		coord_t new_goal_y;
		coord_t new_goal_z;
		coord_t new_vel_x;
		coord_t new_vel_y;
		coord_t new_vel_z;
		coord_t new_heading;
		logic outside_error;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic start_div;
		logic start_mul;
		logic sel_goal;
		logic wb_div;
		logic wb_empty;
		logic wb_mul;
		logic [1:0] axis;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] outside;
		logic any;
		logic size_pos;
		logic done;
	} dp_stat_t;

endpackage

// File: rtl/bbpu_arith.sv
// Shared serial unit: restoring divider and shift-add multiplier.
module bbpu_arith
	import bbpu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic mul,
	input logic [DVW-1:0] dividend,
	input logic [DVW-1:0] divisor,
	input logic [RND_W-1:0] multiplier,
	output logic [DVW-1:0] quo,
	output logic [DVW-1:0] rem,
	output logic [CW-1:0] prod,
	output logic done
);

	localparam int ACCW = DVW + RND_W;
	localparam int STEPS = (DVW > RND_W) ? DVW : RND_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic busy_q, done_q, mul_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVW-1:0] rem_q, quo_q, b_q;
	logic [ACCW-1:0] acc_q;
	logic [RND_W-1:0] mbits_q;
	logic [DVW:0] shifted, diff;

	assign shifted = {rem_q, quo_q[DVW-1]};
	assign diff = shifted - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= mul ? CNT_W'(RND_W) : CNT_W'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			mul_q <= mul;
			b_q <= divisor;
			quo_q <= dividend;
			rem_q <= '0;
			acc_q <= '0;
			mbits_q <= multiplier;
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q <= {acc_q[ACCW-2:0], 1'b0} +
					(mbits_q[RND_W-1] ? {{RND_W{1'b0}}, b_q} : '0);
				mbits_q <= {mbits_q[RND_W-2:0], 1'b0};
			end else if (!diff[DVW]) begin
				rem_q <= diff[DVW-1:0];
				quo_q <= {quo_q[DVW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVW-1:0];
				quo_q <= {quo_q[DVW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;
	assign prod = acc_q[RND_W +: CW];
	assign done = done_q;

endmodule

// File: rtl/bbpu_dp.sv
// Datapath: item registers, fold/wrap/placement arithmetic, random generator.
module bbpu_dp
	import bbpu_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input ctrl_cmd_t cmd,
	input in_item_t in_data,
	input coord_t [2:0] area_min,
	input coord_t [2:0] area_max,
	input logic [1:0] mode,
	input logic seed_wr,
	input logic [RND_W-1:0] seed_val,
	output dp_stat_t stat,
	output out_item_t res
);

	localparam int EW = CW + FRAC_BITS + 10;
	localparam logic signed [EW-1:0] C180 = EW'(180) << FRAC_BITS;
	localparam logic signed [EW-1:0] MAX_E = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [EW-1:0] MIN_E = ~MAX_E;
	localparam coord_t MAX_C = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t MIN_C = {1'b1, {(CW-1){1'b0}}};

	function automatic coord_t sat_c(input logic signed [EW-1:0] x);
		if (x > MAX_E)
			return MAX_C;
		else if (x < MIN_E)
			return MIN_C;
		else
			return x[CW-1:0];
	endfunction

	function automatic logic [RND_W-1:0] xs_next(input logic [RND_W-1:0] s);
		logic [RND_W-1:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	coord_t pos_q [3];
	coord_t goal_q [3];
	coord_t vel_q [3];
	coord_t head_q;
	logic [2:0] outside_q;
	logic [RND_W-1:0] gen_q, gen_nx;

	logic [1:0] ax;
	coord_t lo, hi, coord;
	logic signed [CW:0] size, v;
	logic [DVW-1:0] mag, quo, rem, r, fold;
	logic neg, rnz, odd, size_pos, done;
	coord_t newc, prod, p, vel_neg;
	logic signed [EW-1:0] head_e;

	assign ax = cmd.axis;
	assign lo = area_min[ax];
	assign hi = area_max[ax];
	assign coord = cmd.sel_goal ? goal_q[ax] : pos_q[ax];
	assign size = {hi[CW-1], hi} - {lo[CW-1], lo};
	assign size_pos = !size[CW] && (size != '0);
	assign v = {coord[CW-1], coord} - {lo[CW-1], lo};
	assign neg = v[CW];
	assign mag = neg ? DVW'(-v) : DVW'(v);
	assign gen_nx = xs_next(gen_q);

	bbpu_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start_div || cmd.start_mul),
		.mul(cmd.start_mul),
		.dividend(mag),
		.divisor(DVW'(size)),
		.multiplier(gen_nx),
		.quo(quo),
		.rem(rem),
		.prod(prod),
		.done(done)
	);

	// floor division from the magnitude result
	assign rnz = rem != '0;
	assign r = (neg && rnz) ? DVW'(size) - rem : rem;
	assign odd = (neg && rnz) ? !quo[0] : quo[0];
	always_comb begin
		fold = r;
		if (mode == MODE_REFLECT && odd)
			fold = (r == '0) ? '0 : DVW'(size) - r;
	end
	assign newc = CW'(fold) + lo;
	assign p = size_pos ? lo + prod : lo;
	assign vel_neg = (vel_q[ax] == MIN_C) ? MAX_C : -vel_q[ax];
	assign head_e = EW'(head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gen_q <= RND_W'(1);
		else if (seed_wr)
			gen_q <= (seed_val == '0) ? RND_W'(1) : seed_val;
		else if (cmd.start_mul)
			gen_q <= gen_nx;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q[0] <= in_data.pos_x;
			pos_q[1] <= in_data.pos_y;
			pos_q[2] <= in_data.pos_z;
			goal_q[0] <= in_data.goal_x;
			goal_q[1] <= in_data.goal_y;
			goal_q[2] <= in_data.goal_z;
			vel_q[0] <= in_data.vel_x;
			vel_q[1] <= in_data.vel_y;
			vel_q[2] <= in_data.vel_z;
			head_q <= in_data.heading;
			outside_q[0] <= in_data.pos_x < area_min[0] || in_data.pos_x > area_max[0];
			outside_q[1] <= in_data.pos_y < area_min[1] || in_data.pos_y > area_max[1];
			outside_q[2] <= in_data.pos_z < area_min[2] || in_data.pos_z > area_max[2];
		end else if (cmd.wb_empty) begin
			pos_q[ax] <= lo;
			goal_q[ax] <= lo;
		end else if (cmd.wb_div) begin
			if (cmd.sel_goal) begin
				goal_q[ax] <= newc;
			end else begin
				pos_q[ax] <= newc;
				if (mode == MODE_REFLECT && odd) begin
					vel_q[ax] <= vel_neg;
					if (ax == 2'd0)
						head_q <= sat_c(C180 - head_e);
					else if (ax == 2'd1)
						head_q <= sat_c(-head_e);
				end
			end
		end else if (cmd.wb_mul) begin
			pos_q[ax] <= p;
			goal_q[ax] <= sat_c(EW'(goal_q[ax]) + EW'(p) - EW'(pos_q[ax]));
		end
	end

	assign stat.outside = outside_q;
	assign stat.any = |outside_q;
	assign stat.size_pos = size_pos;
	assign stat.done = done;

	assign res.new_pos_x = pos_q[0];
	assign res.new_pos_y = pos_q[1];
	assign res.new_pos_z = pos_q[2];
	assign res.new_goal_x = goal_q[0];
	assign res.new_goal_y = goal_q[1];
	assign res.new_goal_z = goal_q[2];
	assign res.new_vel_x = vel_q[0];
	assign res.new_vel_y = vel_q[1];
	assign res.new_vel_z = vel_q[2];
	assign res.new_heading = head_q;
	assign res.outside_error = (mode == MODE_ERROR) && (|outside_q);

endmodule

// File: rtl/bbpu_ctrl.sv
// Controller: sequences axes and the shared divide/multiply unit.
module bbpu_ctrl
	import bbpu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_free,
	input logic [1:0] mode,
	input dp_stat_t stat,
	output logic in_stall,
	output logic load_out,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_AXIS = 3'd1;
	localparam logic [2:0] ST_WAIT_P = 3'd2;
	localparam logic [2:0] ST_GO_G = 3'd3;
	localparam logic [2:0] ST_WAIT_G = 3'd4;
	localparam logic [2:0] ST_WAIT_R = 3'd5;
	localparam logic [2:0] ST_NEXT = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] ax_q, ax_d;

	always_comb begin
		state_d = state_q;
		ax_d = ax_q;
		cmd = '0;
		cmd.axis = ax_q;
		load_out = 1'b0;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					ax_d = 2'd0;
					state_d = ST_AXIS;
				end
			end
			ST_AXIS: begin
				if (mode inside {MODE_REFLECT, MODE_WRAP}) begin
					if (!stat.outside[ax_q])
						state_d = ST_NEXT;
					else if (!stat.size_pos) begin
						cmd.wb_empty = 1'b1;
						state_d = ST_NEXT;
					end else begin
						cmd.start_div = 1'b1;
						state_d = ST_WAIT_P;
					end
				end else if (mode == MODE_RANDOM && stat.any) begin
					cmd.start_mul = 1'b1;
					state_d = ST_WAIT_R;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_WAIT_P: begin
				if (stat.done) begin
					cmd.wb_div = 1'b1;
					state_d = ST_GO_G;
				end
			end
			ST_GO_G: begin
				cmd.sel_goal = 1'b1;
				cmd.start_div = 1'b1;
				state_d = ST_WAIT_G;
			end
			ST_WAIT_G: begin
				cmd.sel_goal = 1'b1;
				if (stat.done) begin
					cmd.wb_div = 1'b1;
					state_d = ST_NEXT;
				end
			end
			ST_WAIT_R: begin
				if (stat.done) begin
					cmd.wb_mul = 1'b1;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (ax_q == 2'd2)
					state_d = ST_FINISH;
				else begin
					ax_d = ax_q + 2'd1;
					state_d = ST_AXIS;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q <= 2'd0;
		end else begin
			state_q <= state_d;
			ax_q <= ax_d;
		end
	end

endmodule

// File: rtl/box_border_policy_unit.sv
// Top level: configuration registers, output register, controller and datapath.
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  in_data (in_item_t)
//  out      out  out_valid/out_stall out_data (out_item_t)
//  cfg      in   APB psel/penable   paddr, pwdata, prdata
//
// One request at a time. An axis that needs folding costs two 33-step
// passes of the shared serial divider, each with its own start and write-back;
// a placement costs one 32-step multiply per axis.
// Reset is asynchronous; it clears the controller and loads the generator with 1.
// A finished result waits in the output register while the next request is taken.
module box_border_policy_unit
	import bbpu_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic pready
);

	localparam coord_t MAX_COORD = {1'b0, {(CW-1){1'b1}}};

	coord_t [2:0] min_q, max_q;
	logic [1:0] mode_q;
	logic [RND_W-1:0] seed_q;
	logic [REG_IDX_W-1:0] idx;
	logic wr, seed_wr, out_free, load_out, out_valid_q;
	out_item_t out_q, res;
	ctrl_cmd_t cmd;
	dp_stat_t stat;

	assign pready = 1'b1;
	assign idx = paddr[ADDR_W-1 -: REG_IDX_W];
	assign wr = psel && penable && pwrite;
	assign seed_wr = wr && idx == REG_SEED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= {3{MAX_COORD}};
			mode_q <= MODE_REFLECT;
			seed_q <= RND_W'(1);
		end else if (wr) begin
			case (idx)
				REG_MIN_X: min_q[0] <= pwdata[CW-1:0];
				REG_MIN_Y: min_q[1] <= pwdata[CW-1:0];
				REG_MIN_Z: min_q[2] <= pwdata[CW-1:0];
				REG_MAX_X: max_q[0] <= pwdata[CW-1:0];
				REG_MAX_Y: max_q[1] <= pwdata[CW-1:0];
				REG_MAX_Z: max_q[2] <= pwdata[CW-1:0];
				REG_MODE: mode_q <= pwdata[1:0];
				REG_SEED: seed_q <= pwdata[RND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_X: prdata = CFG_DW'(min_q[0]);
			REG_MIN_Y: prdata = CFG_DW'(min_q[1]);
			REG_MIN_Z: prdata = CFG_DW'(min_q[2]);
			REG_MAX_X: prdata = CFG_DW'(max_q[0]);
			REG_MAX_Y: prdata = CFG_DW'(max_q[1]);
			REG_MAX_Z: prdata = CFG_DW'(max_q[2]);
			REG_MODE: prdata = CFG_DW'(mode_q);
			REG_SEED: prdata = CFG_DW'(seed_q);
			default: prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	bbpu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_free(out_free),
		.mode(mode_q),
		.stat(stat),
		.in_stall(in_stall),
		.load_out(load_out),
		.cmd(cmd)
	);

	bbpu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_data(in_data),
		.area_min(min_q),
		.area_max(max_q),
		.mode(mode_q),
		.seed_wr(seed_wr),
		.seed_val(pwdata[RND_W-1:0]),
		.stat(stat),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: rtl/bbpu_checker.sv
// Port-level checks for the box border policy unit, bound to the top level.
module bbpu_checker
	import bbpu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_data,
	input logic pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared with no processing time");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port not ready");

endmodule

bind box_border_policy_unit bbpu_checker u_bbpu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data),
	.pready(pready)
);
